// ===== rtl/ffba_pkg.sv =====
// ffba_pkg: shared types and constants for the first-fit block allocator.
// Used by ffba_alu, ffba_table and first_fit_block_allocator_core; no dependencies.
`default_nettype none

package ffba_pkg;

	localparam int FIELD_W = 16;

	localparam logic [FIELD_W-1:0] RESET_HEAP_BASE = 16'h0400;
	localparam logic [FIELD_W-1:0] RESET_HEAP_SIZE = 16'h3C00;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOFIT    = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_SIZE = 1'b1;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_FREE  = 2'd1,
		MARK_USED  = 2'd2
	} mark_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WAIT,
		S_ALLOC_CHK,
		S_LAST_CHK,
		S_SHIFT_UP,
		S_SPLIT_WR,
		S_USED_WR,
		S_FREE_CHK,
		S_MERGE_CHK,
		S_SHIFT_DN,
		S_CLR_LAST,
		S_FREE_WR,
		S_INIT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/ffba_alu.sv =====
// ffba_alu: shared add/subtract unit used for the size and start-address compares and the address and length sums.
// Depends on ffba_pkg (alu_op_t).
`default_nettype none

module ffba_alu #(
	parameter int WIDTH = 16
) (
	input  ffba_pkg::alu_op_t op,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output logic [WIDTH-1:0]  sum,
	output logic              carry
);

	logic             sub;
	logic [WIDTH-1:0] b_op;

	assign sub  = (op == ffba_pkg::ALU_SUB);
	assign b_op = sub ? ~b : b;

	// for subtract, carry set means a >= b
	assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, sub};

endmodule

`default_nettype wire

// ===== rtl/ffba_table.sv =====
// ffba_table: block table memory, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as the reset table. Depends on ffba_pkg.
`default_nettype none

module ffba_table #(
	parameter int ENTRIES = 8,
	parameter int WIDTH   = 16,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [WIDTH-1:0]  rd_start,
	output logic [WIDTH-1:0]  rd_length,
	output ffba_pkg::mark_t   rd_mark,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [WIDTH-1:0]  wr_start,
	input  logic [WIDTH-1:0]  wr_length,
	input  ffba_pkg::mark_t   wr_mark
);

	localparam int CW = (WIDTH > ffba_pkg::FIELD_W) ? WIDTH : ffba_pkg::FIELD_W;
	localparam logic [CW-1:0] RST_BASE = CW'(ffba_pkg::RESET_HEAP_BASE);
	localparam logic [CW-1:0] RST_SIZE = CW'(ffba_pkg::RESET_HEAP_SIZE);

	logic [WIDTH-1:0]  mem_start [ENTRIES];
	logic [WIDTH-1:0]  mem_len   [ENTRIES];
	ffba_pkg::mark_t   mem_mark  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [WIDTH-1:0]  rd_start_q;
	logic [WIDTH-1:0]  rd_len_q;
	ffba_pkg::mark_t   rd_mark_q;
	logic              rd_vld_q;
	logic              rd_first_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_start[wr_idx] <= wr_start;
			mem_len[wr_idx]   <= wr_length;
			mem_mark[wr_idx]  <= wr_mark;
		end
		rd_start_q <= mem_start[rd_idx];
		rd_len_q   <= mem_len[rd_idx];
		rd_mark_q  <= mem_mark[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_vld_q   <= 1'b0;
			rd_first_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			rd_vld_q   <= valid_q[rd_idx];
			rd_first_q <= (rd_idx == '0);
		end
	end

	always_comb begin
		if (rd_vld_q) begin
			rd_start  = rd_start_q;
			rd_length = rd_len_q;
			rd_mark   = rd_mark_q;
		end else if (rd_first_q) begin
			rd_start  = RST_BASE[WIDTH-1:0];
			rd_length = RST_SIZE[WIDTH-1:0];
			rd_mark   = ffba_pkg::MARK_FREE;
		end else begin
			rd_start  = '0;
			rd_length = '0;
			rd_mark   = ffba_pkg::MARK_EMPTY;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator_core.sv =====
// first_fit_block_allocator_core: first-fit heap block allocator, top level.
// Sequencer around ffba_table and one shared ffba_alu. Depends on ffba_pkg.
//
// Usage: a request transaction (command, request_size, block_address) is taken
// when in_valid is high and in_stall low. Command allocate scans the table for
// the first free block that fits and splits off any remainder; free looks up the
// block by start address, marks it free and merges the free blocks after it;
// reinitialize rebuilds the table from heap_base/heap_size; the unused code just
// answers ok. Each request gives one result transaction (granted_address, status).
// Every table read goes through the single registered read port, so each check
// waits in S_WAIT for its data. Allocate scans from entry 0 for the fit; a split
// checks that the last entry is empty and shifts the later entries up. Free scans
// for the block, then merges each free block after it by shifting the table down;
// reinitialize writes every entry. One request is worked on at a time; in_stall
// is high meanwhile. The result sits in an output register; the next request is
// accepted while it waits, and finishes only once out_stall lets the old result go.
// Reset: config returns to base 0x400, size 0x3C00, and the table reads as one free
// block over that region at once (no clearing pass). Config writes are taken any
// time and only matter at the next reinitialize.
`default_nettype none

module first_fit_block_allocator_core #(
	parameter int TABLE_ENTRIES = 8,
	parameter int ADDRESS_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [ffba_pkg::FIELD_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     command,
	input  logic [ffba_pkg::FIELD_W-1:0]   request_size,
	input  logic [ffba_pkg::FIELD_W-1:0]   block_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffba_pkg::FIELD_W-1:0]   granted_address,
	output logic [1:0]                     status
);

	localparam int FW = ffba_pkg::FIELD_W;
	localparam int W  = ADDRESS_BITS;
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = (W > FW) ? W : FW;
	localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_ENTRIES - 1);
	localparam logic [IW-1:0] PENULT_IDX = IW'(TABLE_ENTRIES - 2);

	ffba_pkg::state_t state_q, state_d, ret_q;

	logic [IW-1:0] idx_q, x_q, x_next;
	logic [W-1:0]  cur_start_q, cur_len_q, rest_q;
	logic [FW-1:0] size_q, addr_q;
	logic [FW-1:0] base_q, hsize_q;
	logic [FW-1:0] res_addr_q;
	logic [1:0]    res_stat_q;
	logic          out_valid_q;
	logic [FW-1:0] out_addr_q;
	logic [1:0]    out_stat_q;

	logic [W-1:0]    e_start, e_len;
	ffba_pkg::mark_t e_mark;

	logic            wr_en;
	logic [IW-1:0]   wr_idx;
	logic [W-1:0]    wr_start, wr_len;
	ffba_pkg::mark_t wr_mark;

	ffba_pkg::alu_op_t alu_op;
	logic [CW-1:0]     alu_a, alu_b, alu_sum;
	logic              alu_carry;

	logic [CW-1:0] size_ext, base_ext, hsize_ext, cur_start_ext;
	logic          fit, rest_zero, hit, res_load;

	assign size_ext      = CW'(size_q);
	assign base_ext      = CW'(base_q);
	assign hsize_ext     = CW'(hsize_q);
	assign cur_start_ext = CW'(cur_start_q);
	assign x_next        = x_q + IW'(1);

	assign fit       = (e_mark == ffba_pkg::MARK_FREE) && alu_carry;
	assign rest_zero = (alu_sum == '0);
	assign hit       = (e_mark != ffba_pkg::MARK_EMPTY) && (alu_sum == '0);
	assign res_load  = (state_q == ffba_pkg::S_DONE) && (!out_valid_q || !out_stall);

	ffba_table #(
		.ENTRIES (TABLE_ENTRIES),
		.WIDTH   (W),
		.IDX_W   (IW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (idx_q),
		.rd_start  (e_start),
		.rd_length (e_len),
		.rd_mark   (e_mark),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_start  (wr_start),
		.wr_length (wr_len),
		.wr_mark   (wr_mark)
	);

	ffba_alu #(
		.WIDTH (CW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (in_valid) begin
					case (command)
						ffba_pkg::CMD_ALLOC: state_d = ffba_pkg::S_WAIT;
						ffba_pkg::CMD_FREE:  state_d = ffba_pkg::S_WAIT;
						ffba_pkg::CMD_INIT:  state_d = ffba_pkg::S_INIT;
						default:             state_d = ffba_pkg::S_DONE;
					endcase
				end
			end
			ffba_pkg::S_WAIT: state_d = ret_q;
			ffba_pkg::S_ALLOC_CHK: begin
				if (fit) begin
					state_d = rest_zero ? ffba_pkg::S_USED_WR : ffba_pkg::S_WAIT;
				end else begin
					state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_DONE : ffba_pkg::S_WAIT;
				end
			end
			ffba_pkg::S_LAST_CHK: begin
				if (e_mark != ffba_pkg::MARK_EMPTY) begin
					state_d = ffba_pkg::S_DONE;
				end else if (x_q == PENULT_IDX) begin
					state_d = ffba_pkg::S_SPLIT_WR;
				end else begin
					state_d = ffba_pkg::S_WAIT;
				end
			end
			ffba_pkg::S_SHIFT_UP: begin
				state_d = (idx_q == x_next) ? ffba_pkg::S_SPLIT_WR : ffba_pkg::S_WAIT;
			end
			ffba_pkg::S_SPLIT_WR: state_d = ffba_pkg::S_USED_WR;
			ffba_pkg::S_USED_WR:  state_d = ffba_pkg::S_DONE;
			ffba_pkg::S_FREE_CHK: begin
				if (hit) begin
					state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_FREE_WR : ffba_pkg::S_WAIT;
				end else begin
					state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_DONE : ffba_pkg::S_WAIT;
				end
			end
			ffba_pkg::S_MERGE_CHK: begin
				if (e_mark == ffba_pkg::MARK_FREE) begin
					state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_CLR_LAST : ffba_pkg::S_WAIT;
				end else begin
					state_d = ffba_pkg::S_FREE_WR;
				end
			end
			ffba_pkg::S_SHIFT_DN: begin
				state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_CLR_LAST : ffba_pkg::S_WAIT;
			end
			ffba_pkg::S_CLR_LAST: state_d = ffba_pkg::S_WAIT;
			ffba_pkg::S_FREE_WR:  state_d = ffba_pkg::S_DONE;
			ffba_pkg::S_INIT: begin
				state_d = (idx_q == LAST_IDX) ? ffba_pkg::S_DONE : ffba_pkg::S_INIT;
			end
			ffba_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// alu and table write controls
	always_comb begin
		alu_op   = ffba_pkg::ALU_SUB;
		alu_a    = '0;
		alu_b    = '0;
		wr_en    = 1'b0;
		wr_idx   = idx_q;
		wr_start = '0;
		wr_len   = '0;
		wr_mark  = ffba_pkg::MARK_EMPTY;
		case (state_q)
			ffba_pkg::S_ALLOC_CHK: begin
				alu_a = CW'(e_len);
				alu_b = size_ext;
			end
			ffba_pkg::S_FREE_CHK: begin
				alu_a = CW'(e_start);
				alu_b = CW'(addr_q);
			end
			ffba_pkg::S_MERGE_CHK: begin
				alu_op = ffba_pkg::ALU_ADD;
				alu_a  = CW'(cur_len_q);
				alu_b  = CW'(e_len);
			end
			ffba_pkg::S_SHIFT_UP: begin
				wr_en    = 1'b1;
				wr_idx   = idx_q + IW'(1);
				wr_start = e_start;
				wr_len   = e_len;
				wr_mark  = e_mark;
			end
			ffba_pkg::S_SPLIT_WR: begin
				alu_op   = ffba_pkg::ALU_ADD;
				alu_a    = cur_start_ext;
				alu_b    = size_ext;
				wr_en    = 1'b1;
				wr_idx   = x_next;
				wr_start = alu_sum[W-1:0];
				wr_len   = rest_q;
				wr_mark  = ffba_pkg::MARK_FREE;
			end
			ffba_pkg::S_USED_WR: begin
				wr_en    = 1'b1;
				wr_idx   = x_q;
				wr_start = cur_start_q;
				wr_len   = size_ext[W-1:0];
				wr_mark  = ffba_pkg::MARK_USED;
			end
			ffba_pkg::S_SHIFT_DN: begin
				wr_en    = 1'b1;
				wr_idx   = idx_q - IW'(1);
				wr_start = e_start;
				wr_len   = e_len;
				wr_mark  = e_mark;
			end
			ffba_pkg::S_CLR_LAST: begin
				wr_en  = 1'b1;
				wr_idx = LAST_IDX;
			end
			ffba_pkg::S_FREE_WR: begin
				wr_en    = 1'b1;
				wr_idx   = x_q;
				wr_start = cur_start_q;
				wr_len   = cur_len_q;
				wr_mark  = ffba_pkg::MARK_FREE;
			end
			ffba_pkg::S_INIT: begin
				wr_en = 1'b1;
				if (idx_q == '0) begin
					wr_start = base_ext[W-1:0];
					wr_len   = hsize_ext[W-1:0];
					wr_mark  = ffba_pkg::MARK_FREE;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffba_pkg::S_IDLE;
			ret_q       <= ffba_pkg::S_IDLE;
			idx_q       <= '0;
			x_q         <= '0;
			base_q      <= ffba_pkg::RESET_HEAP_BASE;
			hsize_q     <= ffba_pkg::RESET_HEAP_SIZE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= res_load || (out_valid_q && out_stall);

			if (cfg_write) begin
				case (cfg_index)
					ffba_pkg::CFG_HEAP_BASE: base_q  <= cfg_data;
					ffba_pkg::CFG_HEAP_SIZE: hsize_q <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				ffba_pkg::S_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						ret_q <= (command == ffba_pkg::CMD_FREE) ?
							ffba_pkg::S_FREE_CHK : ffba_pkg::S_ALLOC_CHK;
					end
				end
				ffba_pkg::S_ALLOC_CHK: begin
					if (fit) begin
						x_q <= idx_q;
						if (!rest_zero) begin
							idx_q <= LAST_IDX;
							ret_q <= ffba_pkg::S_LAST_CHK;
						end
					end else if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ffba_pkg::S_LAST_CHK: begin
					if (e_mark == ffba_pkg::MARK_EMPTY && x_q != PENULT_IDX) begin
						idx_q <= PENULT_IDX;
						ret_q <= ffba_pkg::S_SHIFT_UP;
					end
				end
				ffba_pkg::S_SHIFT_UP: begin
					if (idx_q != x_next) begin
						idx_q <= idx_q - IW'(1);
					end
				end
				ffba_pkg::S_FREE_CHK: begin
					if (hit) begin
						x_q <= idx_q;
						if (idx_q != LAST_IDX) begin
							idx_q <= idx_q + IW'(1);
							ret_q <= ffba_pkg::S_MERGE_CHK;
						end
					end else if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ffba_pkg::S_MERGE_CHK: begin
					if (e_mark == ffba_pkg::MARK_FREE && idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
						ret_q <= ffba_pkg::S_SHIFT_DN;
					end
				end
				ffba_pkg::S_SHIFT_DN: begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ffba_pkg::S_CLR_LAST: begin
					idx_q <= x_next;
					ret_q <= ffba_pkg::S_MERGE_CHK;
				end
				ffba_pkg::S_INIT: begin
					if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (in_valid) begin
					size_q     <= request_size;
					addr_q     <= block_address;
					res_addr_q <= '0;
					res_stat_q <= ffba_pkg::STAT_OK;
				end
			end
			ffba_pkg::S_ALLOC_CHK: begin
				if (fit) begin
					cur_start_q <= e_start;
					rest_q      <= alu_sum[W-1:0];
				end else if (idx_q == LAST_IDX) begin
					res_stat_q <= ffba_pkg::STAT_NOFIT;
				end
			end
			ffba_pkg::S_LAST_CHK: begin
				if (e_mark != ffba_pkg::MARK_EMPTY) begin
					res_stat_q <= ffba_pkg::STAT_FULL;
				end
			end
			ffba_pkg::S_USED_WR: begin
				res_addr_q <= cur_start_ext[FW-1:0];
			end
			ffba_pkg::S_FREE_CHK: begin
				if (hit) begin
					cur_start_q <= e_start;
					cur_len_q   <= e_len;
				end else if (idx_q == LAST_IDX) begin
					res_stat_q <= ffba_pkg::STAT_NOTFOUND;
				end
			end
			ffba_pkg::S_MERGE_CHK: begin
				if (e_mark == ffba_pkg::MARK_FREE) begin
					cur_len_q <= alu_sum[W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			out_addr_q <= res_addr_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign in_stall        = (state_q != ffba_pkg::S_IDLE);
	assign out_valid       = out_valid_q;
	assign granted_address = out_addr_q;
	assign status          = out_stat_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but sequencer did not go busy");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffba_pkg::S_IDLE || state_q == ffba_pkg::S_DONE) |-> !wr_en)
		else $error("table written outside a request");

	a_wr_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_idx <= LAST_IDX))
		else $error("table write index beyond last entry");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_stat_q == ffba_pkg::STAT_OK || out_addr_q == '0))
		else $error("failed request returned a nonzero address");

endmodule

`default_nettype wire
